@@ sv/ft3d_pkg.sv @@
`timescale 1ns / 1ps
package ft3d_pkg;

    typedef logic [2:0] cmd_t;
    typedef logic [2:0] cfg_addr_t;

    localparam cmd_t CMD_PT_LOCAL    = 3'd0;
    localparam cmd_t CMD_VEC_LOCAL   = 3'd1;
    localparam cmd_t CMD_GRAD_LOCAL  = 3'd2;
    localparam cmd_t CMD_PT_GLOBAL   = 3'd3;
    localparam cmd_t CMD_VEC_GLOBAL  = 3'd4;
    localparam cmd_t CMD_GRAD_GLOBAL = 3'd5;

    localparam cfg_addr_t REG_ORIGIN_X = 3'd0;
    localparam cfg_addr_t REG_ORIGIN_Y = 3'd1;
    localparam cfg_addr_t REG_ORIGIN_Z = 3'd2;
    localparam cfg_addr_t REG_AXIS_X   = 3'd3;
    localparam cfg_addr_t REG_AXIS_Y   = 3'd4;
    localparam cfg_addr_t REG_AXIS_Z   = 3'd5;

    // load enables for the two register ranks of one matrix pass
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } pass_ctrl_t;

endpackage

@@ sv/ft3d_cfg_if.sv @@
`timescale 1ns / 1ps
interface ft3d_cfg_if import ft3d_pkg::*; #(
    parameter int DW = 54
);
    logic          valid;
    logic          ready;
    cfg_addr_t     addr;
    logic [DW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ sv/ft3d_req_if.sv @@
`timescale 1ns / 1ps
interface ft3d_req_if import ft3d_pkg::*; #(
    parameter int EW = 32
);
    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    logic signed [EW-1:0] in_e0;
    logic signed [EW-1:0] in_e1;
    logic signed [EW-1:0] in_e2;
    logic signed [EW-1:0] in_e3;
    logic signed [EW-1:0] in_e4;
    logic signed [EW-1:0] in_e5;
    logic signed [EW-1:0] in_e6;
    logic signed [EW-1:0] in_e7;
    logic signed [EW-1:0] in_e8;

    modport source (output valid, command, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5,
                    in_e6, in_e7, in_e8, input ready);
    modport sink   (input valid, command, in_e0, in_e1, in_e2, in_e3, in_e4, in_e5,
                    in_e6, in_e7, in_e8, output ready);
endinterface

@@ sv/ft3d_rsp_if.sv @@
`timescale 1ns / 1ps
interface ft3d_rsp_if import ft3d_pkg::*; #(
    parameter int EW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [EW-1:0] out_e0;
    logic signed [EW-1:0] out_e1;
    logic signed [EW-1:0] out_e2;
    logic signed [EW-1:0] out_e3;
    logic signed [EW-1:0] out_e4;
    logic signed [EW-1:0] out_e5;
    logic signed [EW-1:0] out_e6;
    logic signed [EW-1:0] out_e7;
    logic signed [EW-1:0] out_e8;
    logic                 saturated;

    modport source (output valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5,
                    out_e6, out_e7, out_e8, saturated, input ready);
    modport sink   (input valid, out_e0, out_e1, out_e2, out_e3, out_e4, out_e5,
                    out_e6, out_e7, out_e8, saturated, output ready);
endinterface

@@ sv/ft3d_mat_pass.sv @@
`timescale 1ns / 1ps
// y[i][j] = (sum_k a[i][k] * b[k][j]) >>> SHIFT
// rank 1: 27 products, rank 2: three-term sums, shifted.
// Sums wider than 64 bits wrap at 64 bits.
module ft3d_mat_pass import ft3d_pkg::*; #(
    parameter int A_W   = 37,
    parameter int B_W   = 18,
    parameter int SHIFT = 16,
    parameter int O_W   = (((A_W + B_W + 2) > 64) ? 64 : (A_W + B_W + 2)) - SHIFT
) (
    input  logic                  clk,
    input  pass_ctrl_t            ctrl,
    input  logic signed [A_W-1:0] a [3][3],
    input  logic signed [B_W-1:0] b [3][3],
    output logic signed [O_W-1:0] y [3][3]
);

    localparam int P_W = A_W + B_W;
    localparam int F_W = P_W + 2;
    localparam int S_W = (F_W > 64) ? 64 : F_W;

    logic signed [P_W-1:0] prod_reg [3][3][3];
    logic signed [F_W-1:0] sum_full [3][3];
    logic signed [O_W-1:0] y_reg    [3][3];

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[i][j][k] <= P_W'(a[i][k]) * P_W'(b[k][j]);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_full[i][j] = F_W'(prod_reg[i][j][0]) + F_W'(prod_reg[i][j][1])
                               + F_W'(prod_reg[i][j][2]);
            end
        end
    end

    // keep the low S_W bits, then drop SHIFT fraction bits (floor)
    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    y_reg[i][j] <= sum_full[i][j][S_W-1:SHIFT];
                end
            end
        end
    end

    assign y = y_reg;

endmodule

@@ sv/frame_transform_3d_core.sv @@
`timescale 1ns / 1ps
// channel | dir | beat contents
// --------+-----+----------------------------------------------
// cfg     | in  | addr (register 0..5), data (origin or packed axis)
// req     | in  | command, in_e0..in_e8
// rsp     | out | out_e0..out_e8, saturated
//
// One beat per cycle sustained while rsp.ready is high.
// Two matrix passes of 27 multipliers each (products ranked, then sums ranked)
// with operand select and saturation stages around them.
// Reset: origin zero, axes identity, pipeline empty.
// Stalls: each stage holds while the next is full and stalled; bubbles close up,
// so req.ready stays high while rsp.ready is high.
module frame_transform_3d_core import ft3d_pkg::*; #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int AXIS_WIDTH    = 18
) (
    input  logic       clk,
    input  logic       rst_n,
    ft3d_cfg_if.sink   cfg,
    ft3d_req_if.sink   req,
    ft3d_rsp_if.source rsp
);

    localparam int EW     = ELEMENT_WIDTH;
    localparam int AW     = AXIS_WIDTH;
    localparam int AW3    = 3 * AW;
    localparam int SH     = AW - 2;
    localparam int XW     = ((EW + 5) > 64) ? 64 : (EW + 5);
    localparam int FW     = XW + AW + 2;
    localparam int SW     = (FW > 64) ? 64 : FW;
    localparam int OW     = SW - SH;
    localparam int STAGES = 7;

    localparam logic [AW3-1:0] AXIS_ONE = {{(AW3 - 1){1'b0}}, 1'b1};
    localparam logic [AW3-1:0] AXIS_X_RST = AXIS_ONE << SH;
    localparam logic [AW3-1:0] AXIS_Y_RST = AXIS_ONE << (SH + AW);
    localparam logic [AW3-1:0] AXIS_Z_RST = AXIS_ONE << (SH + 2 * AW);
    localparam logic signed [EW-1:0] EL_MAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic signed [EW-1:0] EL_MIN = {1'b1, {(EW - 1){1'b0}}};

    // ---------------- configuration ----------------
    logic signed [EW-1:0] origin_reg [3];
    logic [AW3-1:0]       axis_reg   [3];
    logic signed [AW-1:0] r          [3][3];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            axis_reg[0]   <= AXIS_X_RST;
            axis_reg[1]   <= AXIS_Y_RST;
            axis_reg[2]   <= AXIS_Z_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                REG_ORIGIN_X: origin_reg[0] <= cfg.data[EW-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= cfg.data[EW-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= cfg.data[EW-1:0];
                REG_AXIS_X:   axis_reg[0]   <= cfg.data[AW3-1:0];
                REG_AXIS_Y:   axis_reg[1]   <= cfg.data[AW3-1:0];
                REG_AXIS_Z:   axis_reg[2]   <= cfg.data[AW3-1:0];
                default:      ;
            endcase
        end
    end

    // rows of r are the axes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                r[i][k] = axis_reg[i][k*AW +: AW];
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic [STAGES:1]   v_reg;
    logic [STAGES+1:1] en;
    cmd_t              cmd_reg [1:STAGES];

    always_comb
    begin
        en[STAGES+1] = rsp.ready;
        for (int s = STAGES; s >= 1; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign req.ready = en[1];
    assign rsp.valid = v_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= req.valid;
            end
            for (int s = 2; s <= STAGES; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cmd_reg[1] <= req.command;
        end
        for (int s = 2; s <= STAGES; s++)
        begin
            if (en[s])
            begin
                cmd_reg[s] <= cmd_reg[s-1];
            end
        end
    end

    // ---------------- stage 1: operand select ----------------
    logic signed [EW-1:0] e_in     [9];
    logic signed [XW-1:0] g_next   [3][3];
    logic signed [XW-1:0] g_reg    [3][3];
    logic signed [XW-1:0] vec_next [3];
    logic signed [XW-1:0] vec_reg  [1:3][3];

    assign e_in[0] = req.in_e0;
    assign e_in[1] = req.in_e1;
    assign e_in[2] = req.in_e2;
    assign e_in[3] = req.in_e3;
    assign e_in[4] = req.in_e4;
    assign e_in[5] = req.in_e5;
    assign e_in[6] = req.in_e6;
    assign e_in[7] = req.in_e7;
    assign e_in[8] = req.in_e8;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_next[i][k] = XW'(e_in[3*i+k]);
            end
        end
        // point to global: first pass forms R*o in row 0
        if (req.command == CMD_PT_GLOBAL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    g_next[i][k] = (i == 0) ? XW'(origin_reg[k]) : '0;
                end
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (req.command == CMD_PT_LOCAL)
            begin
                vec_next[k] = XW'(e_in[k]) - XW'(origin_reg[k]);
            end
            else
            begin
                vec_next[k] = XW'(e_in[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            g_reg      <= g_next;
            vec_reg[1] <= vec_next;
        end
        if (en[2])
        begin
            vec_reg[2] <= vec_reg[1];
        end
        if (en[3])
        begin
            vec_reg[3] <= vec_reg[2];
        end
    end

    // ---------------- stages 2-3: first pass, X = G * W^T ----------------
    logic signed [AW-1:0] b1    [3][3];
    logic signed [OW-1:0] x1    [3][3];
    logic signed [XW-1:0] xs    [3][3];
    pass_ctrl_t           ctrl1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                b1[k][j] = (cmd_reg[1] == CMD_GRAD_GLOBAL) ? r[k][j] : r[j][k];
            end
        end
    end

    assign ctrl1.prod_en = en[2];
    assign ctrl1.sum_en  = en[3];

    ft3d_mat_pass #(
        .A_W   (XW),
        .B_W   (AW),
        .SHIFT (SH),
        .O_W   (OW)
    ) u_pass1 (
        .clk  (clk),
        .ctrl (ctrl1),
        .a    (g_reg),
        .b    (b1),
        .y    (x1)
    );

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_xs_row
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_xs_col
            if (OW >= XW)
            begin : g_trunc
                assign xs[gi][gj] = x1[gi][gj][XW-1:0];
            end
            else
            begin : g_ext
                assign xs[gi][gj] = {{(XW - OW){x1[gi][gj][OW-1]}}, x1[gi][gj]};
            end
        end
    end

    // ---------------- stage 4: second-pass operand ----------------
    logic signed [XW-1:0] p_next [3][3];
    logic signed [XW-1:0] p_reg  [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_next[k][j] = '0;
            end
        end
        case (cmd_reg[3])
            CMD_GRAD_LOCAL, CMD_GRAD_GLOBAL:
            begin
                p_next = xs;
            end
            CMD_PT_GLOBAL:
            begin
                // p - R*o, column 0
                for (int k = 0; k < 3; k++)
                begin
                    p_next[k][0] = vec_reg[3][k] - xs[0][k];
                end
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    p_next[k][0] = vec_reg[3][k];
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            p_reg <= p_next;
        end
    end

    // ---------------- stages 5-6: second pass, Y = W * P ----------------
    logic signed [AW-1:0] a2 [3][3];
    logic signed [OW-1:0] y2 [3][3];
    logic                 to_global;
    pass_ctrl_t           ctrl2;

    assign to_global = (cmd_reg[4] == CMD_PT_GLOBAL) || (cmd_reg[4] == CMD_VEC_GLOBAL)
                    || (cmd_reg[4] == CMD_GRAD_GLOBAL);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a2[i][k] = to_global ? r[k][i] : r[i][k];
            end
        end
    end

    assign ctrl2.prod_en = en[5];
    assign ctrl2.sum_en  = en[6];

    ft3d_mat_pass #(
        .A_W   (AW),
        .B_W   (XW),
        .SHIFT (SH),
        .O_W   (OW)
    ) u_pass2 (
        .clk  (clk),
        .ctrl (ctrl2),
        .a    (a2),
        .b    (p_reg),
        .y    (y2)
    );

    // ---------------- stage 7: saturate and place ----------------
    logic signed [EW-1:0] sat_val  [3][3];
    logic                 clip     [3][3];
    logic signed [EW-1:0] out_next [9];
    logic                 sat_next;
    logic signed [EW-1:0] out_reg  [9];
    logic                 sat_reg;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_sat_row
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_sat_col
            if (OW > EW)
            begin : g_clip
                logic fits;
                assign fits = (&y2[gi][gj][OW-1:EW-1]) || !(|y2[gi][gj][OW-1:EW-1]);
                assign clip[gi][gj] = !fits;
                assign sat_val[gi][gj] = fits ? y2[gi][gj][EW-1:0]
                                       : (y2[gi][gj][OW-1] ? EL_MIN : EL_MAX);
            end
            else
            begin : g_noclip
                assign clip[gi][gj]    = 1'b0;
                assign sat_val[gi][gj] = EW'(y2[gi][gj]);
            end
        end
    end

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            out_next[n] = '0;
        end
        sat_next = 1'b0;
        case (cmd_reg[6])
            CMD_GRAD_LOCAL, CMD_GRAD_GLOBAL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        out_next[3*i+j] = sat_val[i][j];
                        sat_next        = sat_next | clip[i][j];
                    end
                end
            end
            CMD_PT_LOCAL, CMD_VEC_LOCAL, CMD_PT_GLOBAL, CMD_VEC_GLOBAL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    out_next[i] = sat_val[i][0];
                    sat_next    = sat_next | clip[i][0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign rsp.out_e0    = out_reg[0];
    assign rsp.out_e1    = out_reg[1];
    assign rsp.out_e2    = out_reg[2];
    assign rsp.out_e3    = out_reg[3];
    assign rsp.out_e4    = out_reg[4];
    assign rsp.out_e5    = out_reg[5];
    assign rsp.out_e6    = out_reg[6];
    assign rsp.out_e7    = out_reg[7];
    assign rsp.out_e8    = out_reg[8];
    assign rsp.saturated = sat_reg;

    // ---------------- assertions ----------------
    // a free output side never stalls the input
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.ready |-> req.ready)
        else $error("input stalled while output ready");

    // bubbles ahead of the output close up
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[6] && !v_reg[7] |=> v_reg[7])
        else $error("beat held behind an empty output stage");

    a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] && (cmd_reg[7] == CMD_PT_LOCAL || cmd_reg[7] == CMD_VEC_LOCAL
                     || cmd_reg[7] == CMD_PT_GLOBAL || cmd_reg[7] == CMD_VEC_GLOBAL)
        |-> out_reg[3] == '0 && out_reg[4] == '0 && out_reg[5] == '0
            && out_reg[6] == '0 && out_reg[7] == '0 && out_reg[8] == '0)
        else $error("vector result with non-zero matrix elements");

    a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] && cmd_reg[7] > CMD_GRAD_GLOBAL
        |-> !sat_reg && out_reg[0] == '0 && out_reg[1] == '0 && out_reg[2] == '0)
        else $error("unknown command gave a non-zero result");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import ft3d_pkg::*;

    localparam int EW           = 32;
    localparam int AW           = 18;
    localparam int AXIS_FRAC    = AW - 2;
    localparam int PAD          = 3 * AW - EW;
    localparam int ONE          = 1 << AXIS_FRAC;
    localparam int AXIS_MAX     = (1 << (AW - 1)) - 1;
    localparam int AXIS_MIN     = -(1 << (AW - 1));
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 75;

    localparam logic [EW-1:0] ELEM_MAX = {1'b0, {(EW - 1){1'b1}}};
    localparam logic [EW-1:0] ELEM_MIN = {1'b1, {(EW - 1){1'b0}}};

    // the two codes the block does not decode
    localparam cmd_t CMD_RSVD_6 = 3'd6;
    localparam cmd_t CMD_RSVD_7 = 3'd7;

    typedef logic [8:0][EW-1:0] elems_t;

    typedef struct packed {
        elems_t e;
        logic   saturated;
    } frame_result_t;

    typedef enum int {
        FRAME_IDENTITY,
        FRAME_PERMUTED,
        FRAME_ROTATION_LIKE,
        FRAME_RANDOM,
        FRAME_EXTREME
    } frame_kind_t;

    logic clk;
    logic rst_n;

    ft3d_cfg_if #(.DW(3 * AW)) cfg_ch ();
    ft3d_req_if #(.EW(EW))     req_ch ();
    ft3d_rsp_if #(.EW(EW))     rsp_ch ();

    frame_transform_3d_core #(
        .ELEMENT_WIDTH(EW),
        .AXIS_WIDTH   (AW)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    cmd_t all_cmds [8] = '{CMD_PT_LOCAL, CMD_VEC_LOCAL, CMD_GRAD_LOCAL, CMD_PT_GLOBAL,
                           CMD_VEC_GLOBAL, CMD_GRAD_GLOBAL, CMD_RSVD_6, CMD_RSVD_7};
    int idle_pct_by_phase  [4] = '{0, 57, 0, 15};
    int stall_pct_by_phase [4] = '{0, 0, 57, 15};

    // frame currently held by the block
    logic [EW-1:0]     origin_q [3];
    logic [3*AW-1:0]   axis_q   [3];

    frame_result_t expected_frames [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles;
    int errors    = 0;
    int n_items   = 0;
    int n_frames  = 0;
    int n_clipped = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint dot_trunc(longint a0, longint a1, longint a2,
                                         longint b0, longint b1, longint b2);
        return (a0 * b0 + a1 * b1 + a2 * b2) >>> AXIS_FRAC;
    endfunction

    function automatic frame_result_t predict_transform(cmd_t cmd, elems_t e_in);
        longint rot [3][3];
        longint m   [3][3];
        longint el  [9];
        longint org [3];
        longint tmp [3];
        longint h   [3][3];
        longint res [9];
        logic signed [AW-1:0] comp;
        frame_result_t r;
        r = '0;
        if (cmd > CMD_GRAD_GLOBAL)
            return r;
        for (int i = 0; i < 9; i++)
        begin
            el[i]  = $signed(e_in[i]);
            res[i] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            org[i] = $signed(origin_q[i]);
            for (int k = 0; k < 3; k++)
            begin
                comp      = axis_q[i][k*AW +: AW];
                rot[i][k] = comp;
            end
        end
        // R towards the local frame, R^T back to the global one
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                m[i][k] = (cmd <= CMD_GRAD_LOCAL) ? rot[i][k] : rot[k][i];
        case (cmd)
            CMD_PT_LOCAL, CMD_PT_GLOBAL:
            begin
                for (int i = 0; i < 3; i++)
                    tmp[i] = el[i] - ((cmd == CMD_PT_LOCAL) ? org[i] :
                             dot_trunc(rot[i][0], rot[i][1], rot[i][2], org[0], org[1], org[2]));
                for (int i = 0; i < 3; i++)
                    res[i] = dot_trunc(m[i][0], m[i][1], m[i][2], tmp[0], tmp[1], tmp[2]);
            end
            CMD_VEC_LOCAL, CMD_VEC_GLOBAL:
            begin
                for (int i = 0; i < 3; i++)
                    res[i] = dot_trunc(m[i][0], m[i][1], m[i][2], el[0], el[1], el[2]);
            end
            default:
            begin
                // G M^T kept at full width, then M on the left
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        h[i][j] = dot_trunc(el[3*i], el[3*i+1], el[3*i+2],
                                            m[j][0], m[j][1], m[j][2]);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        res[3*i+j] = dot_trunc(m[i][0], m[i][1], m[i][2],
                                               h[0][j], h[1][j], h[2][j]);
            end
        endcase
        for (int i = 0; i < 9; i++)
        begin
            if (res[i] > longint'($signed(ELEM_MAX)))
            begin
                r.e[i]      = ELEM_MAX;
                r.saturated = 1'b1;
            end
            else if (res[i] < longint'($signed(ELEM_MIN)))
            begin
                r.e[i]      = ELEM_MIN;
                r.saturated = 1'b1;
            end
            else
                r.e[i] = EW'(res[i]);
        end
        return r;
    endfunction

    function automatic void note_failure(string what);
        errors++;
        if (errors <= REPORT_MAX)
            $display("[%0t] %s", $time, what);
    endfunction

    function automatic logic [3*AW-1:0] pack_axis(int c0, int c1, int c2);
        return {c2[AW-1:0], c1[AW-1:0], c0[AW-1:0]};
    endfunction

    function automatic logic [EW-1:0] rand_element();
        int v;
        case ($urandom_range(0, 7))
            0: return ELEM_MAX;
            1: return ELEM_MIN;
            2: return '0;
            3: return '1;
            4, 5:
            begin
                v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                return EW'(v);
            end
            default: return EW'($urandom);
        endcase
    endfunction

    function automatic elems_t rand_elems();
        elems_t e;
        for (int i = 0; i < 9; i++)
            e[i] = rand_element();
        return e;
    endfunction

    task automatic send_transform(input cmd_t cmd, input elems_t el);
        frame_result_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        want = predict_transform(cmd, el);
        expected_frames.push_back(want);
        n_items++;
        if (want.saturated)
            n_clipped++;
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.in_e0   <= el[0];
        req_ch.in_e1   <= el[1];
        req_ch.in_e2   <= el[2];
        req_ch.in_e3   <= el[3];
        req_ch.in_e4   <= el[4];
        req_ch.in_e5   <= el[5];
        req_ch.in_e6   <= el[6];
        req_ch.in_e7   <= el[7];
        req_ch.in_e8   <= el[8];
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t addr, input logic [3*AW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // only called with the pipeline empty
    task automatic set_frame(input logic [EW-1:0] ox, input logic [EW-1:0] oy,
                             input logic [EW-1:0] oz, input logic [3*AW-1:0] ax,
                             input logic [3*AW-1:0] ay, input logic [3*AW-1:0] az);
        // origin writes carry junk above the element width
        write_reg(REG_ORIGIN_X, {PAD'($urandom), ox});
        write_reg(REG_ORIGIN_Y, {PAD'($urandom), oy});
        write_reg(REG_ORIGIN_Z, {PAD'($urandom), oz});
        write_reg(REG_AXIS_X, ax);
        write_reg(REG_AXIS_Y, ay);
        write_reg(REG_AXIS_Z, az);
        cfg_ch.valid <= 1'b0;
        origin_q = '{ox, oy, oz};
        axis_q   = '{ax, ay, az};
        n_frames++;
    endtask

    task automatic random_frame(input frame_kind_t kind);
        logic [EW-1:0]   o [3];
        logic [3*AW-1:0] a [3];
        int p [3];
        int c [3];
        p[0] = $urandom_range(0, 2);
        p[1] = (p[0] + 1 + $urandom_range(0, 1)) % 3;
        p[2] = 3 - p[0] - p[1];
        for (int i = 0; i < 3; i++)
        begin
            o[i] = (kind == FRAME_EXTREME) ? ($urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN) :
                                             rand_element();
            for (int k = 0; k < 3; k++)
                case (kind)
                    FRAME_IDENTITY:      c[k] = (k == i) ? ONE : 0;
                    FRAME_PERMUTED:      c[k] = (k == p[i]) ? ($urandom_range(0, 1) ? ONE : -ONE) : 0;
                    FRAME_ROTATION_LIKE: c[k] = int'($urandom_range(0, 2 * ONE)) - ONE;
                    FRAME_RANDOM:        c[k] = int'($urandom_range(0, (1 << AW) - 1));
                    default:             c[k] = $urandom_range(0, 1) ? AXIS_MAX : AXIS_MIN;
                endcase
            a[i] = pack_axis(c[0], c[1], c[2]);
        end
        set_frame(o[0], o[1], o[2], a[0], a[1], a[2]);
    endtask

    task automatic test_reset_frame();
        // identity frame and zero origin straight out of reset
        foreach (all_cmds[i])
            send_transform(all_cmds[i], rand_elems());
        send_transform(CMD_VEC_LOCAL, {9{ELEM_MAX}});
        send_transform(CMD_GRAD_GLOBAL, {9{ELEM_MIN}});
        send_transform(CMD_PT_LOCAL, '1);
        settle();
    endtask

    task automatic test_saturation();
        // largest axis magnitudes and origin at the limits: most results clip
        set_frame(ELEM_MAX, ELEM_MIN, ELEM_MAX,
                  pack_axis(AXIS_MAX, AXIS_MIN, AXIS_MAX),
                  pack_axis(AXIS_MIN, AXIS_MIN, AXIS_MAX),
                  pack_axis(AXIS_MAX, AXIS_MAX, AXIS_MIN));
        foreach (all_cmds[i])
            send_transform(all_cmds[i], (i % 2) ? {9{ELEM_MIN}} : {9{ELEM_MAX}});
        settle();
        // degenerate frame: every axis zero
        set_frame(ELEM_MIN, ELEM_MIN, ELEM_MIN, '0, '0, '0);
        send_transform(CMD_PT_GLOBAL, {9{ELEM_MAX}});
        send_transform(CMD_GRAD_LOCAL, rand_elems());
        settle();
    endtask

    task automatic test_random_traffic();
        cmd_t cmd;
        for (int ph = 0; ph < 8; ph++)
        begin
            random_frame(ph < 5 ? frame_kind_t'(ph) : frame_kind_t'($urandom_range(0, 4)));
            send_idle_pct  = idle_pct_by_phase[ph % 4];
            recv_stall_pct = stall_pct_by_phase[ph % 4];
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 15) == 0)
                    cmd = $urandom_range(0, 1) ? CMD_RSVD_7 : CMD_RSVD_6;
                else
                    cmd = cmd_t'($urandom_range(CMD_PT_LOCAL, CMD_GRAD_GLOBAL));
                send_transform(cmd, rand_elems());
            end
            settle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // result side: random back-pressure and in-order comparison
    initial
    begin
        frame_result_t got;
        frame_result_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.e[0]      = rsp_ch.out_e0;
                got.e[1]      = rsp_ch.out_e1;
                got.e[2]      = rsp_ch.out_e2;
                got.e[3]      = rsp_ch.out_e3;
                got.e[4]      = rsp_ch.out_e4;
                got.e[5]      = rsp_ch.out_e5;
                got.e[6]      = rsp_ch.out_e6;
                got.e[7]      = rsp_ch.out_e7;
                got.e[8]      = rsp_ch.out_e8;
                got.saturated = rsp_ch.saturated;
                if (expected_frames.size() == 0)
                    note_failure("result beat with nothing outstanding");
                else
                begin
                    want = expected_frames.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.e[i] !== want.e[i])
                            note_failure($sformatf("out_e%0d: expected %h, got %h",
                                                   i, want.e[i], got.e[i]));
                    if (got.saturated !== want.saturated)
                        note_failure($sformatf("saturated: expected %b, got %b",
                                               want.saturated, got.saturated));
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles, %0d results outstanding",
                 cycles, expected_frames.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.addr    <= REG_ORIGIN_X;
        cfg_ch.data    <= '0;
        req_ch.valid   <= 1'b0;
        req_ch.command <= CMD_PT_LOCAL;
        req_ch.in_e0   <= '0;
        req_ch.in_e1   <= '0;
        req_ch.in_e2   <= '0;
        req_ch.in_e3   <= '0;
        req_ch.in_e4   <= '0;
        req_ch.in_e5   <= '0;
        req_ch.in_e6   <= '0;
        req_ch.in_e7   <= '0;
        req_ch.in_e8   <= '0;
        origin_q = '{'0, '0, '0};
        axis_q   = '{pack_axis(ONE, 0, 0), pack_axis(0, ONE, 0), pack_axis(0, 0, ONE)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_saturation();
        test_random_traffic();

        $display("%0d transforms checked over %0d frame settings, %0d of them clipping;",
                 n_items, n_frames, n_clipped);
        $display("all commands incl. undecoded codes, with and without idle and stall.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
